// ===== hdl/keypad_press_classifier_macros.svh =====
// ----------------------------------------------------------------------------
// Keypad press classifier assertion macros
// Shared property shorthands for the classifier's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_PRESS_CLASSIFIER_MACROS_SVH
`define KEYPAD_PRESS_CLASSIFIER_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define KPC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keypad classifier check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define KPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keypad classifier check failed");

`endif

// ===== hdl/kpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Keypad press classifier package
// Key code table, list cap, item kind codes and the scan-to-list beat type.
// ----------------------------------------------------------------------------
package kpc_pkg;

	localparam int ListCap = 8;
	localparam int HwCapMax = 8;
	localparam int EffCap = (ListCap < 1) ? 1 : ((ListCap > HwCapMax) ? HwCapMax : ListCap);
	localparam int IdxW = (EffCap > 1) ? $clog2(EffCap) : 1;
	localparam int CntW = 4;
	localparam int RdW = CntW + 1;
	localparam int MapW = 64;
	localparam int PosW = 6;
	localparam int CodeW = 6;
	localparam int KindW = 2;

	localparam logic [KindW-1:0] KIND_NEW = 2'd0;
	localparam logic [KindW-1:0] KIND_HELD = 2'd1;
	localparam logic [KindW-1:0] KIND_END = 2'd2;

	localparam logic [CodeW-1:0] CodeTable [0:MapW-1] = '{
		6'd13, 6'd12, 6'd11, 6'd10, 6'd9,  6'd8,  6'd7,  6'd6,
		6'd5,  6'd4,  6'd3,  6'd2,  6'd1,  6'd0,  6'd14, 6'd15,
		6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23,
		6'd24, 6'd25, 6'd26, 6'd27, 6'd40, 6'd39, 6'd38, 6'd37,
		6'd36, 6'd35, 6'd34, 6'd33, 6'd32, 6'd31, 6'd30, 6'd29,
		6'd28, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47,
		6'd48, 6'd49, 6'd50, 6'd51, 6'd52, 6'd60, 6'd59, 6'd58,
		6'd57, 6'd56, 6'd55, 6'd54, 6'd53, 6'd61, 6'd62, 6'd63
	};

	// One scanned position handed from the scanner to the code lists.
	typedef struct packed {
		logic             valid;
		logic             held;
		logic [CodeW-1:0] code;
	} push_t;

endpackage

// ===== hdl/kpc_scan.sv =====
// ----------------------------------------------------------------------------
// Keypad press classifier bit-serial scanner
// Shifts the frame and the previous map one position per cycle.
// ----------------------------------------------------------------------------
module kpc_scan (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [kpc_pkg::MapW-1:0]              frame,
	output kpc_pkg::push_t                        push,
	output logic                                  busy,
	output logic                                  done
);

	logic [kpc_pkg::MapW-1:0] frm_q;
	logic [kpc_pkg::MapW-1:0] prev_q;
	logic [kpc_pkg::PosW-1:0] pos_q;
	logic                     busy_q;

	// Previous map rotates: its low bit is the position under test, and the
	// current frame bit enters at the top, so after a full pass it is the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (busy_q) begin
			prev_q <= {frm_q[0], prev_q[kpc_pkg::MapW-1:1]};
			pos_q  <= pos_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			frm_q <= frame;
		end else if (busy_q) begin
			frm_q <= {1'b0, frm_q[kpc_pkg::MapW-1:1]};
		end
	end

	assign done       = busy_q && (pos_q == {kpc_pkg::PosW{1'b1}});
	assign busy       = busy_q;
	assign push.valid = busy_q && frm_q[0];
	assign push.held  = prev_q[0];
	assign push.code  = kpc_pkg::CodeTable[pos_q];

endmodule

// ===== hdl/kpc_list.sv =====
// ----------------------------------------------------------------------------
// Keypad press classifier code lists and emitter
// Collects capped new and held code lists, then plays them out as beats.
// ----------------------------------------------------------------------------
module kpc_list (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  kpc_pkg::push_t               push,
	input  logic                         scan_done,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic [kpc_pkg::KindW-1:0]    item_kind,
	output logic [kpc_pkg::CodeW-1:0]    key_code,
	output logic [kpc_pkg::CntW-1:0]     new_count,
	output logic [kpc_pkg::CntW-1:0]     held_count,
	output logic                         last,
	output logic                         emitting
);

	logic [kpc_pkg::CodeW-1:0] new_mem  [kpc_pkg::EffCap];
	logic [kpc_pkg::CodeW-1:0] held_mem [kpc_pkg::EffCap];
	logic [kpc_pkg::CntW-1:0]  nnew_q;
	logic [kpc_pkg::CntW-1:0]  nheld_q;
	logic [kpc_pkg::RdW-1:0]   rd_q;
	logic                      emit_q;
	logic                      vld_q;

	logic [kpc_pkg::RdW-1:0]   new_end;
	logic [kpc_pkg::RdW-1:0]   all_end;
	logic [kpc_pkg::RdW-1:0]   held_rd;
	logic                      load;
	logic                      new_room;
	logic                      held_room;
	logic [kpc_pkg::KindW-1:0] nxt_kind;
	logic [kpc_pkg::CodeW-1:0] nxt_code;
	logic                      nxt_end;

	assign new_room  = nnew_q < kpc_pkg::CntW'(kpc_pkg::EffCap);
	assign held_room = nheld_q < kpc_pkg::CntW'(kpc_pkg::EffCap);

	always_ff @(posedge clk) begin
		if (push.valid && !push.held && new_room) begin
			new_mem[nnew_q[kpc_pkg::IdxW-1:0]] <= push.code;
		end
		if (push.valid && push.held && held_room) begin
			held_mem[nheld_q[kpc_pkg::IdxW-1:0]] <= push.code;
		end
	end

	assign new_end = {1'b0, nnew_q};
	assign all_end = new_end + {1'b0, nheld_q};
	assign held_rd = rd_q - new_end;

	always_comb begin
		nxt_end = 1'b0;
		priority if (rd_q < new_end) begin
			nxt_kind = kpc_pkg::KIND_NEW;
			nxt_code = new_mem[rd_q[kpc_pkg::IdxW-1:0]];
		end else if (rd_q < all_end) begin
			nxt_kind = kpc_pkg::KIND_HELD;
			nxt_code = held_mem[held_rd[kpc_pkg::IdxW-1:0]];
		end else begin
			nxt_kind = kpc_pkg::KIND_END;
			nxt_code = '0;
			nxt_end  = 1'b1;
		end
	end

	assign load = emit_q && (!vld_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nnew_q  <= '0;
			nheld_q <= '0;
			rd_q    <= '0;
			emit_q  <= 1'b0;
			vld_q   <= 1'b0;
		end else begin
			if (start) begin
				nnew_q  <= '0;
				nheld_q <= '0;
				rd_q    <= '0;
			end else begin
				if (push.valid && !push.held && new_room) begin
					nnew_q <= nnew_q + 1'b1;
				end
				if (push.valid && push.held && held_room) begin
					nheld_q <= nheld_q + 1'b1;
				end
				if (load) begin
					rd_q <= rd_q + 1'b1;
				end
			end
			if (scan_done) begin
				emit_q <= 1'b1;
			end else if (load && nxt_end) begin
				emit_q <= 1'b0;
			end
			if (load) begin
				vld_q <= 1'b1;
			end else if (!out_stall) begin
				vld_q <= 1'b0;
			end
		end
	end

	// Output register: payload holds while stalled.
	always_ff @(posedge clk) begin
		if (load) begin
			item_kind  <= nxt_kind;
			key_code   <= nxt_code;
			new_count  <= nxt_end ? nnew_q : '0;
			held_count <= nxt_end ? nheld_q : '0;
			last       <= nxt_end;
		end
	end

	assign out_valid = vld_q;
	assign emitting  = emit_q;

endmodule

// ===== hdl/keypad_press_classifier.sv =====
// ----------------------------------------------------------------------------
// Keypad press classifier
// Classes each pressed key of an 8x8 scan frame as new or held, emits codes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / pressed_keys): one beat is a whole
//   64-bit scan frame, bit row*8+col set for a pressed key.
//   Output channel (out_valid / out_stall / item fields): per frame, up to
//   eight new codes, then up to eight held codes (row-major order, surplus
//   dropped), then one end beat with last set and both counts.
// Timing:
//   The scanner walks the frame one position per cycle. When the scan
//   ends, the emit flag is set and the output register then loads the
//   first beat. Emission plays out nnew + nheld + 1 beats (at most 17)
//   and waits while the receiver stalls. A frame's occupancy is set by
//   the bit-serial scan loop plus the emit sequence; one frame at a time.
//   in_stall is high from frame acceptance until the end beat is loaded.
// Reset:
//   arst_n clears the previous map (no key held) and all control state.
// Stall:
//   A stalled output beat holds in the output register; emission waits.
// ----------------------------------------------------------------------------
`include "keypad_press_classifier_macros.svh"

module keypad_press_classifier (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [kpc_pkg::MapW-1:0]          pressed_keys,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [kpc_pkg::KindW-1:0]         item_kind,
	output logic [kpc_pkg::CodeW-1:0]         key_code,
	output logic [kpc_pkg::CntW-1:0]          new_count,
	output logic [kpc_pkg::CntW-1:0]          held_count,
	output logic                              last
);

	kpc_pkg::push_t push;
	logic           scan_busy;
	logic           scan_done;
	logic           emitting;
	logic           start;

	// Take a new frame only when both the scan and the emit sequence are done.
	assign in_stall = scan_busy || emitting;
	assign start    = in_valid && !in_stall;

	// Bit-serial scan: one position per cycle, updates the previous map.
	kpc_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.frame  (pressed_keys),
		.push   (push),
		.busy   (scan_busy),
		.done   (scan_done)
	);

	// Capped code lists and the output sequencer with its output register.
	kpc_list u_list (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.push       (push),
		.scan_done  (scan_done),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.item_kind  (item_kind),
		.key_code   (key_code),
		.new_count  (new_count),
		.held_count (held_count),
		.last       (last),
		.emitting   (emitting)
	);

	// Accepted frame must hold off the next one while it scans.
	`KPC_ASSERT_NEXT(a_busy_after_start, start, in_stall && scan_busy)
	// Scan and emission never overlap.
	`KPC_ASSERT_NOW(a_scan_emit_excl, scan_busy, !emitting)
	// Code beats carry zero counts; end beats carry counts within the cap.
	`KPC_ASSERT_NOW(a_code_counts_zero, out_valid && !last, new_count == '0 && held_count == '0)
	`KPC_ASSERT_NOW(a_end_counts_capped, out_valid && last,
		new_count <= kpc_pkg::CntW'(kpc_pkg::EffCap) && held_count <= kpc_pkg::CntW'(kpc_pkg::EffCap))

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Keypad press classifier testbench
// Drives scan frames into the classifier and checks each emitted beat
// against an independent new/held classification of the same frames. Both
// channels idle and stall at random across several pacing phases.
// ----------------------------------------------------------------------------
package kpc_tb_pkg;

	import kpc_pkg::*;

	// Key code for every matrix position, bit row*8+col.
	localparam logic [5:0] KEY_MAP [64] = '{
		6'd13, 6'd12, 6'd11, 6'd10, 6'd9,  6'd8,  6'd7,  6'd6,
		6'd5,  6'd4,  6'd3,  6'd2,  6'd1,  6'd0,  6'd14, 6'd15,
		6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23,
		6'd24, 6'd25, 6'd26, 6'd27, 6'd40, 6'd39, 6'd38, 6'd37,
		6'd36, 6'd35, 6'd34, 6'd33, 6'd32, 6'd31, 6'd30, 6'd29,
		6'd28, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47,
		6'd48, 6'd49, 6'd50, 6'd51, 6'd52, 6'd60, 6'd59, 6'd58,
		6'd57, 6'd56, 6'd55, 6'd54, 6'd53, 6'd61, 6'd62, 6'd63
	};

	localparam int CLASS_LIMIT = (ListCap < 1) ? 1 : ((ListCap > 8) ? 8 : ListCap);
	localparam int SHOWN_ERRORS = 40;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [CodeW-1:0] code;
		logic [CntW-1:0]  new_cnt;
		logic [CntW-1:0]  held_cnt;
		logic             is_end;
	} key_beat_t;

	class frame_ledger;
		logic [MapW-1:0] prior_frame;
		key_beat_t       due_beats [$];
		int              fails;

		function new();
			prior_frame = '0;
			fails = 0;
		endfunction

		function int pending();
			return due_beats.size();
		endfunction

		task report(string what);
			fails++;
			if (fails <= SHOWN_ERRORS)
				$display("mismatch at %0t: %s", $time, what);
		endtask

		// Classify one accepted frame and queue the beats it yields.
		function void note_frame(logic [MapW-1:0] frame);
			logic [CodeW-1:0] fresh [$];
			logic [CodeW-1:0] kept [$];
			key_beat_t b;
			for (int pos = 0; pos < MapW; pos++) begin
				if (frame[pos]) begin
					if (prior_frame[pos]) begin
						if (kept.size() < CLASS_LIMIT)
							kept.push_back(KEY_MAP[pos]);
					end else if (fresh.size() < CLASS_LIMIT) begin
						fresh.push_back(KEY_MAP[pos]);
					end
				end
			end
			prior_frame = frame;
			foreach (fresh[i]) begin
				b = '{kind: KIND_NEW, code: fresh[i], new_cnt: '0, held_cnt: '0, is_end: 1'b0};
				due_beats.push_back(b);
			end
			foreach (kept[i]) begin
				b = '{kind: KIND_HELD, code: kept[i], new_cnt: '0, held_cnt: '0, is_end: 1'b0};
				due_beats.push_back(b);
			end
			b = '{kind: KIND_END, code: '0, new_cnt: CntW'(fresh.size()),
				held_cnt: CntW'(kept.size()), is_end: 1'b1};
			due_beats.push_back(b);
		endfunction

		task check_item(key_beat_t got);
			key_beat_t want;
			if (due_beats.size() == 0) begin
				report($sformatf("unexpected beat kind=%0d code=%0d", got.kind, got.code));
				return;
			end
			want = due_beats.pop_front();
			if (got.kind !== want.kind)
				report($sformatf("item_kind %0d, want %0d", got.kind, want.kind));
			if (got.code !== want.code)
				report($sformatf("key_code %0d, want %0d", got.code, want.code));
			if (got.new_cnt !== want.new_cnt)
				report($sformatf("new_count %0d, want %0d", got.new_cnt, want.new_cnt));
			if (got.held_cnt !== want.held_cnt)
				report($sformatf("held_count %0d, want %0d", got.held_cnt, want.held_cnt));
			if (got.is_end !== want.is_end)
				report($sformatf("last %0b, want %0b", got.is_end, want.is_end));
		endtask
	endclass

endpackage

module tb;

	import kpc_pkg::*;
	import kpc_tb_pkg::*;

	// Generous ceiling: ~400 frames, each with a full scan, 17 beats under
	// heavy stalling and a long sender gap, taken several times over.
	localparam int CYCLE_LIMIT = 1000000;
	// Long receiver hold-off, well beyond one frame's scan and emission.
	localparam int HOLD_CYCLES = 400;
	// Settle past one frame's occupancy without stalls.
	localparam int SETTLE_CYCLES = 120;
	localparam int PHASE_FRAMES = 88;
	localparam int PRESSURE_FRAMES = 8;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [MapW-1:0]  pressed_keys = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [KindW-1:0] item_kind;
	logic [CodeW-1:0] key_code;
	logic [CntW-1:0]  new_count;
	logic [CntW-1:0]  held_count;
	logic             last;

	// Pacing knobs, in percent of cycles.
	int idle_pct = 0;
	int stall_pct = 0;

	// Hold-off request: the stimulus flips it, the receiver counts it out.
	logic hold_req = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;

	frame_ledger ledger = new();

	keypad_press_classifier dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pressed_keys (pressed_keys),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.item_kind    (item_kind),
		.key_code     (key_code),
		.new_count    (new_count),
		.held_count   (held_count),
		.last         (last)
	);

	always #5 clk = ~clk;

	// Receiver: drive stall at the falling edge. A pending hold-off wins over
	// the random stall and keeps the output blocked for its full count.
	always @(negedge clk) begin : receiver
		if (hold_req != hold_seen) begin
			hold_left = HOLD_CYCLES;
			hold_seen = hold_req;
		end
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = ($urandom_range(99) < stall_pct);
		end
	end

	// Output monitor: a beat moves on a rising edge with valid high and stall
	// low. Values are read before any register update of this edge lands.
	always @(posedge clk) begin : monitor
		key_beat_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{kind: item_kind, code: key_code, new_cnt: new_count,
				held_cnt: held_count, is_end: last};
			ledger.check_item(got);
		end
	end

	// Watchdog: end the run if the cycle budget runs out.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic set_pace(int idle, int stall);
		idle_pct = idle;
		stall_pct = stall;
	endtask

	// Offer one frame, starting at a falling edge. Drop valid for random idle
	// cycles first, then hold the frame until it is taken. Returns at the
	// falling edge after acceptance, with valid still high.
	task automatic offer_frame(logic [MapW-1:0] frame);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		pressed_keys = frame;
		do
			@(posedge clk);
		while (in_stall);
		ledger.note_frame(frame);
		@(negedge clk);
	endtask

	// Hold the sender until every expected beat has come out.
	task automatic wait_drained();
		in_valid = 1'b0;
		while (ledger.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Next random frame. The largest share of frames are small edits of the previous one so
	// that held keys, releases and fresh presses mix; the rest are sparse,
	// dense, empty, full or repeated frames.
	function automatic logic [MapW-1:0] next_frame(logic [MapW-1:0] prev);
		logic [MapW-1:0] f;
		int pick;
		int flips;
		f = prev;
		pick = $urandom_range(99);
		if (pick < 40) begin
			flips = $urandom_range(4, 1);
			repeat (flips) f[$urandom_range(MapW-1)] ^= 1'b1;
		end else if (pick < 65) begin
			f = '0;
			flips = $urandom_range(10, 1);
			repeat (flips) f[$urandom_range(MapW-1)] = 1'b1;
		end else if (pick < 85) begin
			f = {$urandom, $urandom};
		end else if (pick < 90) begin
			f = '0;
		end else if (pick < 95) begin
			f = '1;
		end
		return f;
	endfunction

	initial begin : stimulus
		logic [MapW-1:0] probes [$];
		logic [MapW-1:0] recent;

		// Hold reset, release at a falling edge.
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames: empty, full twice (both classes overflow), a lone
		// key pressed, held, then released while the opposite corner goes
		// down, checkerboards, full and empty again, exactly eight codes per
		// class, a ninth key pressed beside the eight held ones, then each row alone.
		probes = '{
			64'h0, '1, '1, 64'h0,
			64'h1, 64'h1, 64'h8000_0000_0000_0000,
			64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, '1,
			64'h0, 64'hFF, 64'h00FF_00FF, 64'h1FF
		};
		for (int r = 0; r < 8; r++)
			probes.push_back(64'hFF << (8 * r));

		set_pace(0, 0);
		foreach (probes[i])
			offer_frame(probes[i]);
		recent = probes[probes.size() - 1];

		// Back-pressure: block the output for a long stretch while frames keep
		// coming, so the input stalls; then pause until everything drains.
		hold_req = ~hold_req;
		repeat (PRESSURE_FRAMES) begin
			recent = next_frame(recent);
			offer_frame(recent);
		end
		wait_drained();

		// Random frames through each pacing phase: free-running, sparse
		// sender, heavy receiver stall, light idling on both sides.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					set_pace(0, 0);
				end
				1: begin
					set_pace(88, 0);
				end
				2: begin
					set_pace(0, 88);
				end
				default: begin
					set_pace(6, 6);
				end
			endcase
			repeat (PHASE_FRAMES) begin
				recent = next_frame(recent);
				offer_frame(recent);
			end
		end

		// Drain, let the block settle, then give the verdict.
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (ledger.fails == 0 && ledger.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
